@@ sv/ead_pkg.sv @@
package ead_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MulW     = 32;

  typedef enum logic [2:0] {
    REG_ALPHA_PEAK     = 3'd0,
    REG_ALPHA_TEMP     = 3'd1,
    REG_SIGMA_MULTIPLE = 3'd2,
    REG_MEAN_MULTIPLE  = 3'd3,
    REG_ABSOLUTE_LIMIT = 3'd4,
    REG_TEMP_MULTIPLE  = 3'd5,
    REG_MIN_SAMPLES    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] alpha_peak;
    logic [15:0] alpha_temp;
    logic [11:0] sigma_multiple;
    logic [11:0] mean_multiple;
    logic [15:0] absolute_limit;
    logic [11:0] temp_multiple;
    logic [3:0]  min_samples;
  } ead_cfg_t;

  localparam logic [15:0] RST_ALPHA_PEAK     = 16'd6554;
  localparam logic [15:0] RST_ALPHA_TEMP     = 16'd3277;
  localparam logic [11:0] RST_SIGMA_MULTIPLE = 12'd768;
  localparam logic [11:0] RST_MEAN_MULTIPLE  = 12'd640;
  localparam logic [15:0] RST_ABSOLUTE_LIMIT = 16'd18432;
  localparam logic [11:0] RST_TEMP_MULTIPLE  = 12'd333;
  localparam logic [3:0]  RST_MIN_SAMPLES    = 4'd3;

  localparam int unsigned FLAG_SPIKE    = 0;
  localparam int unsigned FLAG_THERMAL  = 1;
  localparam int unsigned FLAG_CRITICAL = 2;

  localparam logic [3:0] COUNT_MAX = 4'd15;

endpackage

@@ sv/ead_mul.sv @@
module ead_mul (
  input  logic                         clk,
  input  logic [ead_pkg::MulW-1:0]     op_a,
  input  logic [ead_pkg::MulW-1:0]     op_b,
  output logic [2*ead_pkg::MulW-1:0]   prod
);
  import ead_pkg::*;

  logic [2*MulW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {{MulW{1'b0}}, op_a} * {{MulW{1'b0}}, op_b};
  end

  assign prod = prod_r;

endmodule

@@ sv/ead_cfg.sv @@
module ead_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ead_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ead_pkg::CfgDataW-1:0]  pwdata,
  output logic [ead_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ead_pkg::ead_cfg_t             cfg
);
  import ead_pkg::*;

  ead_cfg_t cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_peak     <= RST_ALPHA_PEAK;
      cfg_r.alpha_temp     <= RST_ALPHA_TEMP;
      cfg_r.sigma_multiple <= RST_SIGMA_MULTIPLE;
      cfg_r.mean_multiple  <= RST_MEAN_MULTIPLE;
      cfg_r.absolute_limit <= RST_ABSOLUTE_LIMIT;
      cfg_r.temp_multiple  <= RST_TEMP_MULTIPLE;
      cfg_r.min_samples    <= RST_MIN_SAMPLES;
    end else if (wr_en) begin
      unique case (idx)
        REG_ALPHA_PEAK:     cfg_r.alpha_peak     <= pwdata[15:0];
        REG_ALPHA_TEMP:     cfg_r.alpha_temp     <= pwdata[15:0];
        REG_SIGMA_MULTIPLE: cfg_r.sigma_multiple <= pwdata[11:0];
        REG_MEAN_MULTIPLE:  cfg_r.mean_multiple  <= pwdata[11:0];
        REG_ABSOLUTE_LIMIT: cfg_r.absolute_limit <= pwdata[15:0];
        REG_TEMP_MULTIPLE:  cfg_r.temp_multiple  <= pwdata[11:0];
        REG_MIN_SAMPLES:    cfg_r.min_samples    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALPHA_PEAK:     prdata = {16'd0, cfg_r.alpha_peak};
      REG_ALPHA_TEMP:     prdata = {16'd0, cfg_r.alpha_temp};
      REG_SIGMA_MULTIPLE: prdata = {20'd0, cfg_r.sigma_multiple};
      REG_MEAN_MULTIPLE:  prdata = {20'd0, cfg_r.mean_multiple};
      REG_ABSOLUTE_LIMIT: prdata = {16'd0, cfg_r.absolute_limit};
      REG_TEMP_MULTIPLE:  prdata = {20'd0, cfg_r.temp_multiple};
      REG_MIN_SAMPLES:    prdata = {28'd0, cfg_r.min_samples};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ sv/ewma_anomaly_detector_core.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_peak_sample, in_temp_sample
// out       out_valid / out_ready  out_anomaly_flags, out_baseline_ready,
//                                  out_mean_level, out_level_variance
// cfg       psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One transaction is in flight at a time; the next is accepted only once the
// previous result is in the output register. Twelve issue slots on the one
// registered 32x32 multiplier and a final update step run in order, then the
// output load, and in_ready is back for the cycle after the load.
// A finished result waits in the output register; in_ready returns as soon as
// the result is loaded there, and a full output register holds the sequencer.
// Synchronous active-low reset clears the baseline, sample count, sequencer state and out_valid.
module ewma_anomaly_detector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   in_peak_sample,
  input  logic signed [15:0]            in_temp_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_anomaly_flags,
  output logic                          out_baseline_ready,
  output logic [15:0]                   out_mean_level,
  output logic [31:0]                   out_level_variance,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ead_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ead_pkg::CfgDataW-1:0]  pwdata,
  output logic [ead_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ead_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  // issue slots of the shared multiplier; results are used in the next step
  localparam logic [3:0] S_KK  = 4'd0;
  localparam logic [3:0] S_RR  = 4'd1;
  localparam logic [3:0] S_KVL = 4'd2;
  localparam logic [3:0] S_AR2 = 4'd3;
  localparam logic [3:0] S_KVH = 4'd4;
  localparam logic [3:0] S_MM  = 4'd5;
  localparam logic [3:0] S_TM  = 4'd6;
  localparam logic [3:0] S_DD  = 4'd7;
  localparam logic [3:0] S_AVL = 4'd8;
  localparam logic [3:0] S_AVH = 4'd9;
  localparam logic [3:0] S_ADM = 4'd10;
  localparam logic [3:0] S_ADT = 4'd11;
  localparam logic [3:0] S_FIN = 4'd12;

  ead_cfg_t cfg;

  state_t state_r, state_nxt;
  logic [3:0] step_r;

  logic [15:0] x_r;
  logic [15:0] t_r;
  logic        ready_r, crit_r, dpos_r, dm_neg_r, dt_neg_r, tm_neg_r;
  logic [31:0] dm_mag_r, dt_mag_r, tm_mag_r;
  logic [15:0] r_mag_r;
  logic [23:0] k2_r;
  logic [31:0] r2_r;
  logic [71:0] kv_r;
  logic [47:0] ar2_r;
  logic [63:0] d2_r;
  logic [63:0] av_r;
  logic [47:0] shrink_r;
  logic        spike_r, therm_r;

  logic [31:0] mean_r;
  logic [47:0] var_r;
  logic [31:0] tmean_r;
  logic [3:0]  count_r;

  logic        out_valid_r, rdy_out_r;
  logic [2:0]  flags_out_r;
  logic [15:0] mean_out_r;
  logic [31:0] var_out_r;

  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;

  logic        accept, load_out;
  logic [31:0] xs, ts, dm_mag, dt_mag, tm_mag;
  logic [15:0] r_mag;
  logic        dge, tge, rge;
  logic        mm_hit, th_hit, sig_hit, step_c;
  logic [46:0] t_ext, mag_ext, th_sum;
  logic [31:0] step_fl, mean_up, tmean_up;
  logic [47:0] var_up, shrink;
  logic [2:0]  flags;

  ead_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ead_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // operand preparation at accept
  assign xs     = {in_peak_sample, 16'd0};
  assign ts     = {in_temp_sample, 16'd0};
  assign dge    = xs >= mean_r;
  assign dm_mag = dge ? xs - mean_r : mean_r - xs;
  assign tge    = $signed(ts) >= $signed(tmean_r);
  assign dt_mag = tge ? ts - tmean_r : tmean_r - ts;
  assign rge    = in_peak_sample >= mean_r[31:16];
  assign r_mag  = rge ? in_peak_sample - mean_r[31:16] : mean_r[31:16] - in_peak_sample;
  assign tm_mag = tmean_r[31] ? 32'd0 - tmean_r : tmean_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      S_KK: begin
        mul_a = {20'd0, cfg.sigma_multiple};
        mul_b = {20'd0, cfg.sigma_multiple};
      end
      S_RR: begin
        mul_a = {16'd0, r_mag_r};
        mul_b = {16'd0, r_mag_r};
      end
      S_KVL: begin
        mul_a = {8'd0, k2_r};
        mul_b = {8'd0, var_r[23:0]};
      end
      S_AR2: begin
        mul_a = {16'd0, cfg.alpha_peak};
        mul_b = r2_r;
      end
      S_KVH: begin
        mul_a = {8'd0, k2_r};
        mul_b = {8'd0, var_r[47:24]};
      end
      S_MM: begin
        mul_a = {20'd0, cfg.mean_multiple};
        mul_b = mean_r;
      end
      S_TM: begin
        mul_a = {20'd0, cfg.temp_multiple};
        mul_b = tm_mag_r;
      end
      S_DD: begin
        mul_a = dm_mag_r;
        mul_b = dm_mag_r;
      end
      S_AVL: begin
        mul_a = {16'd0, cfg.alpha_peak};
        mul_b = {8'd0, var_r[23:0]};
      end
      S_AVH: begin
        mul_a = {16'd0, cfg.alpha_peak};
        mul_b = {8'd0, var_r[47:24]};
      end
      S_ADM: begin
        mul_a = {16'd0, cfg.alpha_peak};
        mul_b = dm_mag_r;
      end
      S_ADT: begin
        mul_a = {16'd0, cfg.alpha_temp};
        mul_b = dt_mag_r;
      end
      default: ;
    endcase
  end

  // tests
  assign mm_hit  = {4'd0, x_r, 24'd0} > mul_p[43:0];
  assign t_ext   = {{7{t_r[15]}}, t_r, 24'd0};
  assign mag_ext = {3'd0, mul_p[43:0]};
  assign th_sum  = tm_neg_r ? t_ext + mag_ext : t_ext - mag_ext;
  assign th_hit  = !th_sum[46] && (th_sum != '0);
  assign sig_hit = dpos_r && ({8'd0, d2_r} > kv_r);

  // floor(+-p / 2^16) applied to an accumulator
  assign step_fl  = mul_p[47:16];
  assign step_c   = |mul_p[15:0];
  assign mean_up  = dm_neg_r ? mean_r - step_fl - {31'd0, step_c} : mean_r + step_fl;
  assign tmean_up = dt_neg_r ? tmean_r - step_fl - {31'd0, step_c} : tmean_r + step_fl;
  assign shrink   = av_r[63:16] + {47'd0, |av_r[15:0]};
  assign var_up   = var_r + ar2_r - shrink_r;

  always_comb begin
    flags                = '0;
    flags[FLAG_SPIKE]    = spike_r;
    flags[FLAG_THERMAL]  = therm_r;
    flags[FLAG_CRITICAL] = crit_r;
    if (!ready_r) begin
      flags = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (step_r == S_FIN) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_KK;
      out_valid_r <= 1'b0;
      mean_r      <= '0;
      var_r       <= '0;
      tmean_r     <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        step_r   <= S_KK;
        x_r      <= in_peak_sample;
        t_r      <= in_temp_sample;
        ready_r  <= count_r >= cfg.min_samples;
        crit_r   <= in_peak_sample > cfg.absolute_limit;
        dpos_r   <= xs > mean_r;
        dm_neg_r <= !dge;
        dm_mag_r <= dm_mag;
        dt_neg_r <= !tge;
        dt_mag_r <= dt_mag;
        r_mag_r  <= r_mag;
        tm_neg_r <= tmean_r[31];
        tm_mag_r <= tm_mag;
        spike_r  <= 1'b0;
        therm_r  <= 1'b0;
      end

      if (state_r == ST_RUN) begin
        step_r <= step_r + 4'd1;
        case (step_r)
          S_RR:  k2_r  <= mul_p[23:0];
          S_KVL: r2_r  <= mul_p[31:0];
          S_AR2: kv_r  <= {24'd0, mul_p[47:0]};
          S_KVH: ar2_r <= mul_p[47:0];
          S_MM:  kv_r  <= kv_r + {mul_p[47:0], 24'd0};
          S_TM:  spike_r <= spike_r | mm_hit;
          S_DD:  therm_r <= th_hit;
          S_AVL: d2_r  <= mul_p;
          S_AVH: begin
            av_r    <= {24'd0, mul_p[39:0]};
            spike_r <= spike_r | sig_hit;
          end
          S_ADM: av_r <= av_r + {mul_p[39:0], 24'd0};
          S_ADT: begin
            mean_r   <= mean_up;
            shrink_r <= shrink;
          end
          S_FIN: begin
            if (count_r == 4'd0) begin
              mean_r  <= {x_r, 16'd0};
              tmean_r <= {t_r, 16'd0};
              var_r   <= '0;
              count_r <= 4'd1;
            end else begin
              tmean_r <= tmean_up;
              var_r   <= var_up;
              if (count_r != COUNT_MAX) begin
                count_r <= count_r + 4'd1;
              end
            end
          end
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
        flags_out_r <= flags;
        rdy_out_r   <= ready_r;
        mean_out_r  <= mean_r[31:16];
        var_out_r   <= var_r[47:16];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_anomaly_flags  = flags_out_r;
  assign out_baseline_ready = rdy_out_r;
  assign out_mean_level     = mean_out_r;
  assign out_level_variance = var_out_r;

endmodule

@@ sv/ead_chk.sv @@
module ead_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_peak_sample,
  input logic [15:0] in_temp_sample,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_anomaly_flags,
  input logic        out_baseline_ready,
  input logic [15:0] out_mean_level,
  input logic [31:0] out_level_variance,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_anomaly_flags)
      && $stable(out_mean_level) && $stable(out_level_variance))
    else $error("result changed while stalled");

  // one transaction in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // no flags before the baseline is ready
  a_flags_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_baseline_ready |-> out_anomaly_flags == 3'd0)
    else $error("flags raised without baseline");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind ewma_anomaly_detector_core ead_chk u_ead_chk (.*);
